FILE: hw/rtl/mask_pyramid_region_query_defines.svh
// Assertion helpers for the region query block.
`ifndef MASK_PYRAMID_REGION_QUERY_DEFINES_SVH
`define MASK_PYRAMID_REGION_QUERY_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included.
`define MPQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

FILE: hw/rtl/mpq_pkg.sv
`default_nettype none
package mpq_pkg;

   localparam int MAX_SIDE    = 256;
   localparam int MAX_LEVELS  = 9;
   localparam int SIDE_W      = $clog2(MAX_SIDE) + 1;
   localparam int POS_W       = $clog2(MAX_SIDE);
   localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
   localparam int STORE_DEPTH = (MAX_SIDE * MAX_SIDE * 4) / 3 + MAX_LEVELS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PROD_W      = 2 * SIDE_W;
   localparam int RED_W       = 2 * POS_W;
   localparam int REG_W       = 9;
   localparam int COORD_W     = 10;
   localparam int LOG_W       = $clog2(COORD_W + 1);
   localparam int CSR_IDX_W   = 2;

   // grey level weights and class thresholds (ties go to the darker class)
   localparam int GREY_W         = 15;
   localparam int GREY_R         = 30;
   localparam int GREY_G         = 59;
   localparam int GREY_B         = 11;
   localparam int CLASS_LO_LIMIT = (128 * 100) / 2;
   localparam int CLASS_HI_LIMIT = (128 * 100 + 255 * 100) / 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      CLS_UNKNOWN = 2'd0,
      CLS_IGNORED = 2'd1,
      CLS_KNOWN   = 2'd2,
      CLS_INDET   = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ANY    = 2'd1,
      MODE_ALL    = 2'd2,
      MODE_REDUCE = 2'd3
   } mode_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [1:0]        wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // first store address of a pyramid level
   function automatic logic [ADDR_W-1:0] level_offset(input logic [LVL_W-1:0] lvl);
      int off;
      int s;
      off = 0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         s = MAX_SIDE >> k;
         if (s < 1) s = 1;
         if (k < int'(lvl)) off = off + s * s;
      end
      return ADDR_W'(off);
   endfunction

   // side of a level: halve per level, never below one
   function automatic logic [SIDE_W-1:0] side_at(input logic [SIDE_W-1:0] d,
                                                 input logic [LVL_W-1:0]  lvl);
      logic [SIDE_W-1:0] s;
      s = d >> lvl;
      if (s == '0) s = SIDE_W'(1);
      return s;
   endfunction

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [REG_W-1:0] v);
      logic [SIDE_W-1:0] s;
      if (v == '0) s = SIDE_W'(1);
      else if (int'(v) > MAX_SIDE) s = SIDE_W'(MAX_SIDE);
      else s = SIDE_W'(v);
      return s;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mpq_store.sv
`default_nettype none
module mpq_store (
   input  wire logic                 clock,
   input  wire mpq_pkg::mem_req_type mem_req,
   output logic [1:0]                rd_data
);

   logic [1:0] mem [mpq_pkg::STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.we) mem[mem_req.waddr] <= mem_req.wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) rd_data <= mem[mem_req.raddr];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/mask_pyramid_region_query.sv
// Mask pyramid with region queries. Mode 0 beats load RGB mask pixels in
// raster order; each is graded unknown, ignored or known and written to
// level 0 of one 2-bit cell store (one write and one read port, registered
// read data). Each pixel is written before the next beat is taken. The
// last pixel of the image starts the pyramid build, which reads every
// source cell once through the read port and writes each coarse cell,
// level by level; no input beat is taken meanwhile. Mode 1 (any) and
// mode 2 (all) queries visit the box cells one at a time through the read
// port, level by level, and stop early on a decisive cell. Mode 3 (reduce)
// copies level 1 into level 0 cell by cell, then rebuilds. Modes 1 to 3
// return one result beat each with the current level count; a load
// returns none. The store has no reset: load a full image before
// querying. Write the image size only while idle; a size write restarts
// the load position and drops the pyramid to one level.
`default_nettype none
module mask_pyramid_region_query (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [7:0]                    req_red,
   input  wire logic [7:0]                    req_green,
   input  wire logic [7:0]                    req_blue,
   input  wire logic signed [9:0]             req_box_left,
   input  wire logic signed [9:0]             req_box_top,
   input  wire logic signed [9:0]             req_box_right,
   input  wire logic signed [9:0]             req_box_bottom,
   input  wire logic [1:0]                    req_query_class,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_answer,
   output logic [3:0]                         rsp_levels_in_use,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mpq_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mpq_pkg::REG_W-1:0]     csr_wdata
);

   `include "mask_pyramid_region_query_defines.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_PIX, ST_B_LVL, ST_B_RD, ST_B_CHK, ST_B_WR,
      ST_R_RD, ST_R_WR, ST_Q_INIT, ST_Q_LVL, ST_Q_RD, ST_Q_CHK, ST_RESP
   } state_type;

   state_type                          state_ff, state_in;
   logic [mpq_pkg::REG_W-1:0]          image_width_ff, image_width_in;
   logic [mpq_pkg::REG_W-1:0]          image_height_ff, image_height_in;
   logic [mpq_pkg::SIDE_W-1:0]         base_w_ff, base_w_in, base_h_ff, base_h_in;
   logic [mpq_pkg::LVL_W-1:0]          level_count_ff, level_count_in;
   logic [mpq_pkg::POS_W-1:0]          load_col_ff, load_col_in, load_row_ff, load_row_in;
   logic [mpq_pkg::RED_W-1:0]          load_addr_ff, load_addr_in;
   logic [mpq_pkg::GREY_W-1:0]         grey_ff, grey_in;
   // build walk
   logic [mpq_pkg::SIDE_W-1:0]         src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [mpq_pkg::SIDE_W-1:0]         dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [mpq_pkg::ADDR_W-1:0]         src_off_ff, src_off_in, dst_off_ff, dst_off_in;
   logic [mpq_pkg::POS_W-1:0]          bx_ff, bx_in, by_ff, by_in;
   logic [1:0]                         bu_ff, bu_in, bv_ff, bv_in;
   logic [1:0]                         acc_ff, acc_in;
   logic                               all_indet_ff, all_indet_in;
   logic                               build_resp_ff, build_resp_in;
   logic [mpq_pkg::RED_W-1:0]          red_idx_ff, red_idx_in;
   // query walk
   logic signed [mpq_pkg::COORD_W-1:0] bl_ff, bl_in, bt_ff, bt_in, br_ff, br_in, bb_ff, bb_in;
   logic [1:0]                         qcls_ff, qcls_in;
   logic                               qany_ff, qany_in;
   logic [mpq_pkg::LVL_W-1:0]          qlvl_ff, qlvl_in;
   logic signed [mpq_pkg::COORD_W-1:0] qx0_ff, qx0_in, qx1_ff, qx1_in, qy1_ff, qy1_in;
   logic signed [mpq_pkg::COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [mpq_pkg::SIDE_W-1:0]         qw_ff, qw_in, qh_ff, qh_in;
   logic [mpq_pkg::ADDR_W-1:0]         qoff_ff, qoff_in;
   logic                               qinside_ff, qinside_in, qindet_ff, qindet_in;
   logic                               ans_ff, ans_in;
   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_answer_ff, rsp_answer_in;
   logic [mpq_pkg::LVL_W-1:0]          rsp_levels_ff, rsp_levels_in;

   mpq_pkg::mem_req_type               mem_req;
   logic [1:0]                         mem_rd_data;

   // scratch
   logic [mpq_pkg::SIDE_W-1:0]         b_row, b_col, half_w, half_h;
   logic [mpq_pkg::PROD_W-1:0]         prod, red_n;
   logic [1:0]                         cls, b_cu, b_cv;
   logic                               ai_next, indet_next;
   logic signed [mpq_pkg::COORD_W:0]   ext_x, ext_y, ext_m;
   logic [mpq_pkg::COORD_W:0]          ext_1;
   logic [mpq_pkg::LOG_W-1:0]          ext_lg;
   logic signed [mpq_pkg::COORD_W-1:0] sx0, sx1, sy0, sy1;

   mpq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   assign req_ready         = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_answer        = rsp_answer_ff;
   assign rsp_levels_in_use = rsp_levels_ff;

   assign half_w = mpq_pkg::side_at(base_w_ff, (mpq_pkg::LVL_W)'(1));
   assign half_h = mpq_pkg::side_at(base_h_ff, (mpq_pkg::LVL_W)'(1));
   assign red_n  = (mpq_pkg::PROD_W)'(half_w) * (mpq_pkg::PROD_W)'(half_h);

   always_comb begin
      state_in        = state_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      base_w_in       = base_w_ff;
      base_h_in       = base_h_ff;
      level_count_in  = level_count_ff;
      load_col_in     = load_col_ff;
      load_row_in     = load_row_ff;
      load_addr_in    = load_addr_ff;
      grey_in         = grey_ff;
      src_w_in        = src_w_ff;
      src_h_in        = src_h_ff;
      dst_w_in        = dst_w_ff;
      dst_h_in        = dst_h_ff;
      src_off_in      = src_off_ff;
      dst_off_in      = dst_off_ff;
      bx_in           = bx_ff;
      by_in           = by_ff;
      bu_in           = bu_ff;
      bv_in           = bv_ff;
      acc_in          = acc_ff;
      all_indet_in    = all_indet_ff;
      build_resp_in   = build_resp_ff;
      red_idx_in      = red_idx_ff;
      bl_in           = bl_ff;
      bt_in           = bt_ff;
      br_in           = br_ff;
      bb_in           = bb_ff;
      qcls_in         = qcls_ff;
      qany_in         = qany_ff;
      qlvl_in         = qlvl_ff;
      qx0_in          = qx0_ff;
      qx1_in          = qx1_ff;
      qy1_in          = qy1_ff;
      qx_in           = qx_ff;
      qy_in           = qy_ff;
      qw_in           = qw_ff;
      qh_in           = qh_ff;
      qoff_in         = qoff_ff;
      qinside_in      = qinside_ff;
      qindet_in       = qindet_ff;
      ans_in          = ans_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_answer_in   = rsp_answer_ff;
      rsp_levels_in   = rsp_levels_ff;
      mem_req         = '0;
      b_row           = '0;
      b_col           = '0;
      prod            = '0;
      cls             = mpq_pkg::CLS_KNOWN;
      b_cu            = 2'd2;
      b_cv            = 2'd2;
      ai_next         = 1'b0;
      indet_next      = 1'b0;
      ext_x           = '0;
      ext_y           = '0;
      ext_m           = '0;
      ext_1           = '0;
      ext_lg          = '0;
      sx0             = '0;
      sx1             = '0;
      sy0             = '0;
      sy1             = '0;

      // drop the result beat once taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               if (csr_index == mpq_pkg::CSR_IMAGE_WIDTH ||
                   csr_index == mpq_pkg::CSR_IMAGE_HEIGHT) begin
                  if (csr_index == mpq_pkg::CSR_IMAGE_WIDTH) begin
                     image_width_in = csr_wdata;
                     base_w_in      = mpq_pkg::clamp_side(csr_wdata);
                     base_h_in      = mpq_pkg::clamp_side(image_height_ff);
                  end else begin
                     image_height_in = csr_wdata;
                     base_w_in       = mpq_pkg::clamp_side(image_width_ff);
                     base_h_in       = mpq_pkg::clamp_side(csr_wdata);
                  end
                  level_count_in = (mpq_pkg::LVL_W)'(1);
                  load_col_in    = '0;
                  load_row_in    = '0;
                  load_addr_in   = '0;
               end
            end else if (req_valid) begin
               unique case (mpq_pkg::mode_type'(req_mode))
                  mpq_pkg::MODE_LOAD: begin
                     grey_in =
                        (mpq_pkg::GREY_W)'(req_red)   * (mpq_pkg::GREY_W)'(mpq_pkg::GREY_R) +
                        (mpq_pkg::GREY_W)'(req_green) * (mpq_pkg::GREY_W)'(mpq_pkg::GREY_G) +
                        (mpq_pkg::GREY_W)'(req_blue)  * (mpq_pkg::GREY_W)'(mpq_pkg::GREY_B);
                     state_in = ST_PIX;
                  end
                  mpq_pkg::MODE_ANY, mpq_pkg::MODE_ALL: begin
                     bl_in    = req_box_left;
                     bt_in    = req_box_top;
                     br_in    = req_box_right;
                     bb_in    = req_box_bottom;
                     qcls_in  = req_query_class;
                     qany_in  = (req_mode == mpq_pkg::MODE_ANY);
                     state_in = ST_Q_INIT;
                  end
                  mpq_pkg::MODE_REDUCE: begin
                     ans_in = 1'b0;
                     if (level_count_ff >= (mpq_pkg::LVL_W)'(2)) begin
                        red_idx_in = '0;
                        state_in   = ST_R_RD;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_PIX: begin
            // grade the pixel and advance the raster position
            if (grey_ff <= (mpq_pkg::GREY_W)'(mpq_pkg::CLASS_LO_LIMIT))
               cls = mpq_pkg::CLS_UNKNOWN;
            else if (grey_ff <= (mpq_pkg::GREY_W)'(mpq_pkg::CLASS_HI_LIMIT))
               cls = mpq_pkg::CLS_IGNORED;
            else
               cls = mpq_pkg::CLS_KNOWN;
            mem_req.we    = 1'b1;
            mem_req.waddr = (mpq_pkg::ADDR_W)'(load_addr_ff);
            mem_req.wdata = cls;
            state_in      = ST_IDLE;
            load_addr_in  = load_addr_ff + 1'b1;
            if ((mpq_pkg::SIDE_W)'(load_col_ff) + 1'b1 >= base_w_ff) begin
               load_col_in = '0;
               if ((mpq_pkg::SIDE_W)'(load_row_ff) + 1'b1 >= base_h_ff) begin
                  // last pixel: start the build from level 0
                  load_row_in    = '0;
                  load_addr_in   = '0;
                  level_count_in = (mpq_pkg::LVL_W)'(1);
                  src_w_in       = base_w_ff;
                  src_h_in       = base_h_ff;
                  build_resp_in  = 1'b0;
                  state_in       = ST_B_LVL;
               end else begin
                  load_row_in = load_row_ff + 1'b1;
               end
            end else begin
               load_col_in = load_col_ff + 1'b1;
            end
         end

         ST_B_LVL: begin
            if (level_count_ff == (mpq_pkg::LVL_W)'(mpq_pkg::MAX_LEVELS) ||
                (src_w_ff == (mpq_pkg::SIDE_W)'(1) && src_h_ff == (mpq_pkg::SIDE_W)'(1))) begin
               ans_in   = 1'b0;
               state_in = build_resp_ff ? ST_RESP : ST_IDLE;
            end else begin
               dst_w_in     = mpq_pkg::side_at(src_w_ff, (mpq_pkg::LVL_W)'(1));
               dst_h_in     = mpq_pkg::side_at(src_h_ff, (mpq_pkg::LVL_W)'(1));
               src_off_in   = mpq_pkg::level_offset(level_count_ff - 1'b1);
               dst_off_in   = mpq_pkg::level_offset(level_count_ff);
               bx_in        = '0;
               by_in        = '0;
               bu_in        = '0;
               bv_in        = '0;
               all_indet_in = 1'b1;
               state_in     = ST_B_RD;
            end
         end

         ST_B_RD: begin
            b_row         = (mpq_pkg::SIDE_W)'({by_ff, 1'b0}) + (mpq_pkg::SIDE_W)'(bv_ff);
            b_col         = (mpq_pkg::SIDE_W)'({bx_ff, 1'b0}) + (mpq_pkg::SIDE_W)'(bu_ff);
            prod          = (mpq_pkg::PROD_W)'(b_row) * (mpq_pkg::PROD_W)'(src_w_ff);
            mem_req.re    = 1'b1;
            mem_req.raddr = src_off_ff + (mpq_pkg::ADDR_W)'(prod) + (mpq_pkg::ADDR_W)'(b_col);
            state_in      = ST_B_CHK;
         end

         ST_B_CHK: begin
            if (bu_ff == 2'd0 && bv_ff == 2'd0) acc_in = mem_rd_data;
            else if (mem_rd_data != acc_ff)    acc_in = mpq_pkg::CLS_INDET;
            // the last group of a row or column widens to the far edge
            if ((mpq_pkg::SIDE_W)'(bx_ff) == dst_w_ff - 1'b1)
               b_cu = 2'(src_w_ff - (mpq_pkg::SIDE_W)'({bx_ff, 1'b0}));
            if ((mpq_pkg::SIDE_W)'(by_ff) == dst_h_ff - 1'b1)
               b_cv = 2'(src_h_ff - (mpq_pkg::SIDE_W)'({by_ff, 1'b0}));
            state_in = ST_B_RD;
            if (bu_ff == b_cu - 1'b1) begin
               bu_in = '0;
               if (bv_ff == b_cv - 1'b1) begin
                  bv_in    = '0;
                  state_in = ST_B_WR;
               end else begin
                  bv_in = bv_ff + 1'b1;
               end
            end else begin
               bu_in = bu_ff + 1'b1;
            end
         end

         ST_B_WR: begin
            prod          = (mpq_pkg::PROD_W)'(by_ff) * (mpq_pkg::PROD_W)'(dst_w_ff);
            mem_req.we    = 1'b1;
            mem_req.waddr = dst_off_ff + (mpq_pkg::ADDR_W)'(prod) + (mpq_pkg::ADDR_W)'(bx_ff);
            mem_req.wdata = acc_ff;
            ai_next       = all_indet_ff && (acc_ff == mpq_pkg::CLS_INDET);
            all_indet_in  = ai_next;
            state_in      = ST_B_RD;
            if ((mpq_pkg::SIDE_W)'(bx_ff) == dst_w_ff - 1'b1) begin
               bx_in = '0;
               if ((mpq_pkg::SIDE_W)'(by_ff) == dst_h_ff - 1'b1) begin
                  // level done: stop on a wholly indeterminate level
                  level_count_in = level_count_ff + 1'b1;
                  if (ai_next) begin
                     ans_in   = 1'b0;
                     state_in = build_resp_ff ? ST_RESP : ST_IDLE;
                  end else begin
                     src_w_in = dst_w_ff;
                     src_h_in = dst_h_ff;
                     state_in = ST_B_LVL;
                  end
               end else begin
                  by_in = by_ff + 1'b1;
               end
            end else begin
               bx_in = bx_ff + 1'b1;
            end
         end

         ST_R_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = mpq_pkg::level_offset((mpq_pkg::LVL_W)'(1)) +
                            (mpq_pkg::ADDR_W)'(red_idx_ff);
            state_in      = ST_R_WR;
         end

         ST_R_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = (mpq_pkg::ADDR_W)'(red_idx_ff);
            mem_req.wdata = (mem_rd_data == mpq_pkg::CLS_INDET) ?
                            mpq_pkg::CLS_UNKNOWN : mem_rd_data;
            if ((mpq_pkg::PROD_W)'(red_idx_ff) == red_n - 1'b1) begin
               base_w_in      = half_w;
               base_h_in      = half_h;
               load_col_in    = '0;
               load_row_in    = '0;
               load_addr_in   = '0;
               level_count_in = (mpq_pkg::LVL_W)'(1);
               src_w_in       = half_w;
               src_h_in       = half_h;
               build_resp_in  = 1'b1;
               state_in       = ST_B_LVL;
            end else begin
               red_idx_in = red_idx_ff + 1'b1;
               state_in   = ST_R_RD;
            end
         end

         ST_Q_INIT: begin
            // start level: floor log2 of the larger extent, capped
            ext_x = {br_ff[mpq_pkg::COORD_W-1], br_ff} - {bl_ff[mpq_pkg::COORD_W-1], bl_ff};
            ext_y = {bb_ff[mpq_pkg::COORD_W-1], bb_ff} - {bt_ff[mpq_pkg::COORD_W-1], bt_ff};
            ext_m = (ext_y > ext_x) ? ext_y : ext_x;
            if (ext_m < 0) ext_m = '0;
            ext_1 = $unsigned(ext_m) + 1'b1;
            for (int i = 0; i <= mpq_pkg::COORD_W; i++) begin
               if (ext_1[i]) ext_lg = (mpq_pkg::LOG_W)'(i);
            end
            if ((mpq_pkg::LOG_W)'(level_count_ff - 1'b1) < ext_lg)
               qlvl_in = level_count_ff - 1'b1;
            else
               qlvl_in = (mpq_pkg::LVL_W)'(ext_lg);
            state_in = ST_Q_LVL;
         end

         ST_Q_LVL: begin
            sx0      = bl_ff >>> qlvl_ff;
            sx1      = br_ff >>> qlvl_ff;
            sy0      = bt_ff >>> qlvl_ff;
            sy1      = bb_ff >>> qlvl_ff;
            qx0_in   = sx0;
            qx1_in   = sx1;
            qy1_in   = sy1;
            qx_in    = sx0;
            qy_in    = sy0;
            qw_in    = mpq_pkg::side_at(base_w_ff, qlvl_ff);
            qh_in    = mpq_pkg::side_at(base_h_ff, qlvl_ff);
            qoff_in  = mpq_pkg::level_offset(qlvl_ff);
            qindet_in = 1'b0;
            if (sx0 > sx1 || sy0 > sy1) begin
               // empty box
               ans_in   = !qany_ff;
               state_in = ST_RESP;
            end else begin
               state_in = ST_Q_RD;
            end
         end

         ST_Q_RD: begin
            qinside_in = !qx_ff[mpq_pkg::COORD_W-1] && !qy_ff[mpq_pkg::COORD_W-1] &&
                         (qx_ff[mpq_pkg::COORD_W-2:0] < qw_ff) &&
                         (qy_ff[mpq_pkg::COORD_W-2:0] < qh_ff);
            prod          = (mpq_pkg::PROD_W)'(qy_ff[mpq_pkg::COORD_W-2:0]) *
                            (mpq_pkg::PROD_W)'(qw_ff);
            mem_req.re    = qinside_in;
            mem_req.raddr = qoff_ff + (mpq_pkg::ADDR_W)'(prod) +
                            (mpq_pkg::ADDR_W)'(qx_ff[mpq_pkg::COORD_W-2:0]);
            state_in      = ST_Q_CHK;
         end

         ST_Q_CHK: begin
            // cells outside the image read as known
            cls        = qinside_ff ? mem_rd_data : mpq_pkg::CLS_KNOWN;
            indet_next = qindet_ff || (cls == mpq_pkg::CLS_INDET);
            qindet_in  = indet_next;
            state_in   = ST_Q_RD;
            if (cls != mpq_pkg::CLS_INDET && ((cls == qcls_ff) == qany_ff)) begin
               ans_in   = qany_ff;
               state_in = ST_RESP;
            end else if (qx_ff == qx1_ff) begin
               qx_in = qx0_ff;
               if (qy_ff == qy1_ff) begin
                  // descend only past indeterminate cells
                  if (!indet_next || qlvl_ff == '0) begin
                     ans_in   = !qany_ff;
                     state_in = ST_RESP;
                  end else begin
                     qlvl_in  = qlvl_ff - 1'b1;
                     state_in = ST_Q_LVL;
                  end
               end else begin
                  qy_in = qy_ff + 1'b1;
               end
            end else begin
               qx_in = qx_ff + 1'b1;
            end
         end

         ST_RESP: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ans_ff;
               rsp_levels_in = level_count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         image_width_ff  <= (mpq_pkg::REG_W)'(mpq_pkg::MAX_SIDE);
         image_height_ff <= (mpq_pkg::REG_W)'(mpq_pkg::MAX_SIDE);
         base_w_ff       <= (mpq_pkg::SIDE_W)'(mpq_pkg::MAX_SIDE);
         base_h_ff       <= (mpq_pkg::SIDE_W)'(mpq_pkg::MAX_SIDE);
         level_count_ff  <= (mpq_pkg::LVL_W)'(1);
         load_col_ff     <= '0;
         load_row_ff     <= '0;
         load_addr_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         base_w_ff       <= base_w_in;
         base_h_ff       <= base_h_in;
         level_count_ff  <= level_count_in;
         load_col_ff     <= load_col_in;
         load_row_ff     <= load_row_in;
         load_addr_ff    <= load_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      grey_ff       <= grey_in;
      src_w_ff      <= src_w_in;
      src_h_ff      <= src_h_in;
      dst_w_ff      <= dst_w_in;
      dst_h_ff      <= dst_h_in;
      src_off_ff    <= src_off_in;
      dst_off_ff    <= dst_off_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      bu_ff         <= bu_in;
      bv_ff         <= bv_in;
      acc_ff        <= acc_in;
      all_indet_ff  <= all_indet_in;
      build_resp_ff <= build_resp_in;
      red_idx_ff    <= red_idx_in;
      bl_ff         <= bl_in;
      bt_ff         <= bt_in;
      br_ff         <= br_in;
      bb_ff         <= bb_in;
      qcls_ff       <= qcls_in;
      qany_ff       <= qany_in;
      qlvl_ff       <= qlvl_in;
      qx0_ff        <= qx0_in;
      qx1_ff        <= qx1_in;
      qy1_ff        <= qy1_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      qw_ff         <= qw_in;
      qh_ff         <= qh_in;
      qoff_ff       <= qoff_in;
      qinside_ff    <= qinside_in;
      qindet_ff     <= qindet_in;
      ans_ff        <= ans_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_levels_ff <= rsp_levels_in;
   end

   `MPQ_ASSERT_ALWAYS(a_level_range, reset || (level_count_ff != '0 && level_count_ff <= (mpq_pkg::LVL_W)'(mpq_pkg::MAX_LEVELS)), "level count out of range")
   `MPQ_ASSERT(a_cfg_restart, csr_valid && csr_ready |=> level_count_ff == (mpq_pkg::LVL_W)'(1) && load_col_ff == '0 && load_row_ff == '0, "size write did not restart")
   `MPQ_ASSERT(a_load_col, (mpq_pkg::SIDE_W)'(load_col_ff) < base_w_ff && (mpq_pkg::SIDE_W)'(load_row_ff) < base_h_ff, "load position past base level")
   `MPQ_ASSERT(a_waddr, mem_req.we |-> mem_req.waddr < (mpq_pkg::ADDR_W)'(mpq_pkg::STORE_DEPTH), "store write out of range")

endmodule
`default_nettype wire
